// File: hdl/bounded_double_ended_queue_macros.svh
// Assertion macros used by the checker file of the double-ended queue.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bdq_pkg.sv
// Types and constants of the bounded double-ended queue.
// No dependencies; every other file but the macro header imports it.
package bdq_pkg;

  localparam int IDX_W  = 4;
  localparam int DEPTH  = 2 ** IDX_W;
  localparam int CNT_W  = IDX_W + 1;
  localparam int WORD_W = 32;
  localparam int REQ_W  = 3;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;

  // command queue between front and back
  localparam int QPTR_W = 1;
  localparam int QDEPTH = 2 ** QPTR_W;
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ_INDEX = 3'd4,
    REQ_READ_LAST  = 3'd5,
    REQ_CLEAR      = 3'd6
  } req_type_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // classified request handed from front to back
  typedef struct packed {
    logic [IDX_W-1:0]  addr;
    logic [WORD_W-1:0] word;
    logic              wr;
    logic              rd;
    status_e           status;
    logic [CNT_W-1:0]  occ;
  } cmd_t;

endpackage

// File: hdl/bdq_if.sv
// Request and response channel interfaces, valid/ready handshake.
// Depends on bdq_pkg.
interface bdq_req_if;
  import bdq_pkg::*;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [WORD_W-1:0] push_word;
  logic [POS_W-1:0]  position;

  modport source (output valid, req_type, push_word, position, input ready);
  modport sink   (input valid, req_type, push_word, position, output ready);
endinterface

interface bdq_rsp_if;
  import bdq_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] read_word;
  logic [STAT_W-1:0] status;
  logic [CNT_W-1:0]  occupancy;

  modport source (output valid, read_word, status, occupancy, input ready);
  modport sink   (input valid, read_word, status, occupancy, output ready);
endinterface

// File: hdl/bdq_front.sv
// Front end: owns the ring pointer and occupancy, classifies each request
// into a slot access and a status. Depends on bdq_pkg.
module bdq_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  logic [bdq_pkg::REQ_W-1:0]  req_type_i,
  input  logic [bdq_pkg::WORD_W-1:0] push_word_i,
  input  logic [bdq_pkg::POS_W-1:0]  position_i,
  output logic                      cmd_valid_o,
  input  logic                      cmd_ready_i,
  output bdq_pkg::cmd_t             cmd_o
);
  import bdq_pkg::*;

  logic [IDX_W-1:0] front_q, front_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             full, empty, in_range, fire;
  logic [IDX_W-1:0] back_slot, tail_slot;
  req_type_e        req;

  assign req       = req_type_e'(req_type_i);
  assign full      = (count_q == CNT_W'(DEPTH));
  assign empty     = (count_q == '0);
  assign in_range  = ((POS_W+CNT_W)'(position_i) < (POS_W+CNT_W)'(count_q));
  assign tail_slot = front_q + count_q[IDX_W-1:0];
  assign back_slot = tail_slot - IDX_W'(1);

  assign req_ready_o = cmd_ready_i;
  assign cmd_valid_o = req_valid_i;
  assign fire        = req_valid_i && cmd_ready_i;

  always_comb begin
    front_d     = front_q;
    count_d     = count_q;
    cmd_o.addr  = front_q;
    cmd_o.word  = push_word_i;
    cmd_o.wr    = 1'b0;
    cmd_o.rd    = 1'b0;
    cmd_o.status = ST_OK;
    case (req)
      REQ_PUSH_FRONT: begin
        if (full) begin
          cmd_o.status = ST_FULL;
        end else begin
          front_d    = front_q - IDX_W'(1);
          cmd_o.addr = front_q - IDX_W'(1);
          cmd_o.wr   = 1'b1;
          count_d    = count_q + CNT_W'(1);
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          cmd_o.status = ST_FULL;
        end else begin
          cmd_o.addr = tail_slot;
          cmd_o.wr   = 1'b1;
          count_d    = count_q + CNT_W'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.rd = 1'b1;
          front_d  = front_q + IDX_W'(1);
          count_d  = count_q - CNT_W'(1);
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.addr = back_slot;
          cmd_o.rd   = 1'b1;
          count_d    = count_q - CNT_W'(1);
        end
      end
      REQ_READ_INDEX: begin
        if (!in_range) begin
          cmd_o.status = ST_RANGE;
        end else begin
          // position is below the count here, so it fits the slot width
          cmd_o.addr = front_q + IDX_W'(position_i);
          cmd_o.rd   = 1'b1;
        end
      end
      REQ_READ_LAST: begin
        if (empty) begin
          cmd_o.status = ST_EMPTY;
        end else begin
          cmd_o.addr = back_slot;
          cmd_o.rd   = 1'b1;
        end
      end
      REQ_CLEAR: begin
        front_d = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
    cmd_o.occ = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (fire) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

endmodule

// File: hdl/bdq_cmdq.sv
// Two-entry command queue decoupling the front end from the back end.
// Depends on bdq_pkg.
module bdq_cmdq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bdq_pkg::cmd_t in_cmd_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bdq_pkg::cmd_t out_cmd_o
);
  import bdq_pkg::*;

  cmd_t              slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != QCNT_W'(QDEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_cmd_o   = slots_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= in_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + QCNT_W'(1);
        2'b01:   cnt_q <= cnt_q - QCNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: hdl/bdq_back.sv
// Back end: ring storage and the registered response stage.
// Depends on bdq_pkg.
module bdq_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  output logic                       cmd_ready_o,
  input  bdq_pkg::cmd_t              cmd_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output logic [bdq_pkg::WORD_W-1:0] read_word_o,
  output logic [bdq_pkg::STAT_W-1:0] status_o,
  output logic [bdq_pkg::CNT_W-1:0]  occupancy_o
);
  import bdq_pkg::*;

  logic [WORD_W-1:0] mem_q [DEPTH];
  logic              valid_q;
  logic [WORD_W-1:0] word_q;
  status_e           status_q;
  logic [CNT_W-1:0]  occ_q;
  logic              take;

  // the response register frees up in the same cycle it is drained
  assign cmd_ready_o = !valid_q || rsp_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;

  always_ff @(posedge clk_i) begin
    if (take && cmd_i.wr) begin
      mem_q[cmd_i.addr] <= cmd_i.word;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      word_q   <= cmd_i.rd ? mem_q[cmd_i.addr] : '0;
      status_q <= cmd_i.status;
      occ_q    <= cmd_i.occ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (cmd_ready_o) begin
      valid_q <= cmd_valid_i;
    end
  end

  assign rsp_valid_o = valid_q;
  assign read_word_o = word_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;

endmodule

// File: hdl/bounded_double_ended_queue.sv
// Bounded double-ended queue: front end, command queue, back end.
// Depends on bdq_pkg, bdq_if, bdq_front, bdq_cmdq, bdq_back.
//
//   channel | modport | fields
//   req_i   | sink    | req_type[2:0], push_word[31:0], position[3:0]
//   rsp_o   | source  | read_word[31:0], status[1:0], occupancy[4:0]
//
// One request per cycle sustained while the response side keeps up. The
// command queue entry is written at the edge that takes a request; the back
// end then reads the storage into its registered response stage.
// Reset clears pointer, occupancy and queue control; storage is not cleared.
// A stalled response backs up the two-entry command queue, then req_i.ready.
module bounded_double_ended_queue (
  input  logic         clk_i,
  input  logic         rst_ni,
  bdq_req_if.sink      req_i,
  bdq_rsp_if.source    rsp_o
);
  import bdq_pkg::*;

  logic cf_valid, cf_ready, cb_valid, cb_ready;
  cmd_t cf_cmd, cb_cmd;

  bdq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_type_i  (req_i.req_type),
    .push_word_i (req_i.push_word),
    .position_i  (req_i.position),
    .cmd_valid_o (cf_valid),
    .cmd_ready_i (cf_ready),
    .cmd_o       (cf_cmd)
  );

  bdq_cmdq u_cmdq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cf_valid),
    .in_ready_o  (cf_ready),
    .in_cmd_i    (cf_cmd),
    .out_valid_o (cb_valid),
    .out_ready_i (cb_ready),
    .out_cmd_o   (cb_cmd)
  );

  bdq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cb_valid),
    .cmd_ready_o (cb_ready),
    .cmd_i       (cb_cmd),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .read_word_o (rsp_o.read_word),
    .status_o    (rsp_o.status),
    .occupancy_o (rsp_o.occupancy)
  );

endmodule

// File: hdl/bdq_checker.sv
// Port-level checks on the response channel of the double-ended queue.
// Depends on bdq_pkg and bounded_double_ended_queue_macros.svh.
`include "bounded_double_ended_queue_macros.svh"

module bdq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [bdq_pkg::WORD_W-1:0] read_word_i,
  input logic [bdq_pkg::STAT_W-1:0] status_i,
  input logic [bdq_pkg::CNT_W-1:0]  occupancy_i
);
  import bdq_pkg::*;

  `BDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(read_word_i) && $stable(status_i) && $stable(occupancy_i), "response changed while stalled")
  `BDQ_ASSERT_NOW(a_err_zero, rsp_valid_i && (status_i != ST_OK), read_word_i == '0, "non-zero word on error status")
  `BDQ_ASSERT_NOW(a_occ_bound, rsp_valid_i, occupancy_i <= CNT_W'(DEPTH), "occupancy beyond depth")
  `BDQ_ASSERT_NOW(a_full_occ, rsp_valid_i && (status_i == ST_FULL), occupancy_i == CNT_W'(DEPTH), "full status without full queue")
  `BDQ_ASSERT_NOW(a_empty_occ, rsp_valid_i && (status_i == ST_EMPTY), occupancy_i == '0, "empty status with entries stored")

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .rsp_valid_i (rsp_o.valid),
  .rsp_ready_i (rsp_o.ready),
  .read_word_i (rsp_o.read_word),
  .status_i    (rsp_o.status),
  .occupancy_i (rsp_o.occupancy)
);

// File: tb/bdq_response_checker.sv
// Response checker for the bounded double-ended queue: watches both channels,
// predicts each response from the transferred requests and compares in order.
// Depends on bdq_pkg and bdq_if.
module bdq_response_checker (
  input  logic  clk_i,
  input  logic  rst_ni,
  bdq_req_if    req_i,
  bdq_rsp_if    rsp_i,
  output int    fail_count_o,
  output int    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import bdq_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    status_e           status;
    logic [CNT_W-1:0]  occ;
  } response_t;

  // predicted queue contents
  logic [WORD_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]  head  = '0;
  logic [CNT_W-1:0]  count = '0;

  response_t expected_q [$];
  response_t want;
  response_t seen;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  function automatic response_t apply_request(input logic [REQ_W-1:0]  code,
                                              input logic [WORD_W-1:0] word,
                                              input logic [POS_W-1:0]  pos);
    response_t        r;
    logic [IDX_W-1:0] slot;
    r.word   = '0;
    r.status = ST_OK;
    case (code)
      REQ_PUSH_FRONT: begin
        if (count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head       = head - 1'b1;
          ring[head] = word;
          count      = count + 1'b1;
        end
      end
      REQ_PUSH_BACK: begin
        if (count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot       = head + count[IDX_W-1:0];
          ring[slot] = word;
          count      = count + 1'b1;
        end
      end
      REQ_POP_FRONT: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.word = ring[head];
          head   = head + 1'b1;
          count  = count - 1'b1;
        end
      end
      REQ_POP_BACK: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot   = head + count[IDX_W-1:0] - 1'b1;
          r.word = ring[slot];
          count  = count - 1'b1;
        end
      end
      REQ_READ_INDEX: begin
        if (CNT_W'(pos) >= count) begin
          r.status = ST_RANGE;
        end else begin
          slot   = head + pos;
          r.word = ring[slot];
        end
      end
      REQ_READ_LAST: begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot   = head + count[IDX_W-1:0] - 1'b1;
          r.word = ring[slot];
        end
      end
      REQ_CLEAR: begin
        head  = '0;
        count = '0;
      end
      default: ;  // unused code leaves the queue alone
    endcase
    r.occ = count;
    return r;
  endfunction

  // sampled mid-cycle: everything driven at the rising edge has settled
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      head  = '0;
      count = '0;
    end else begin
      if (req_i.valid && req_i.ready)
        expected_q.push_back(apply_request(req_i.req_type, req_i.push_word,
                                           req_i.position));
      if (rsp_i.valid && rsp_i.ready) begin
        seen.word   = rsp_i.read_word;
        seen.status = status_e'(rsp_i.status);
        seen.occ    = rsp_i.occupancy;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: response with nothing outstanding: word %h status %0d occ %0d",
                     $realtime, seen.word, seen.status, seen.occ);
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.read_word !== want.word || rsp_i.status !== want.status ||
              rsp_i.occupancy !== want.occ) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch: expected word %h status %0d occ %0d, got %h %0d %0d",
                       $realtime, want.word, want.status, want.occ,
                       rsp_i.read_word, rsp_i.status, rsp_i.occupancy);
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: tb/bounded_double_ended_queue_test.sv
// Top of the double-ended queue testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on bdq_pkg, bdq_if,
// bounded_double_ended_queue and bdq_response_checker.
module bounded_double_ended_queue_test;
  timeunit 1ns;
  timeprecision 1ps;
  import bdq_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;
  localparam int LONG_HOLD = 64;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;

  bit sender_gaps   = 1'b0;
  bit receiver_gaps = 1'b0;
  bit hold_long     = 1'b0;

  bdq_req_if req_if ();
  bdq_rsp_if rsp_if ();

  bounded_double_ended_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  bdq_response_checker checker_inst (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #6 clk_i = ~clk_i;

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // offer one request and return at the edge that transfers it
  task automatic send_request(input logic [REQ_W-1:0]  code,
                              input logic [WORD_W-1:0] word,
                              input logic [POS_W-1:0]  pos);
    bit taken;
    taken = 1'b0;
    if (sender_gaps && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= code;
    req_if.push_word <= word;
    req_if.position  <= pos;
    while (!taken) begin
      @(negedge clk_i);
      taken = req_if.ready;
      @(posedge clk_i);
    end
  endtask

  // push_share: percentage of pushes; pops take what is left after clears, unused codes, reads and pushes
  task automatic random_request(input int push_share);
    int               roll;
    logic [REQ_W-1:0] code;
    roll = $urandom_range(0, 99);
    if (roll == 0)
      code = REQ_CLEAR;
    else if (roll == 1)
      code = REQ_UNUSED;
    else if (roll < 12)
      code = REQ_READ_INDEX;
    else if (roll < 18)
      code = REQ_READ_LAST;
    else if (roll < 18 + push_share)
      code = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
    else
      code = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
    send_request(code, $urandom(), POS_W'($urandom_range(0, DEPTH - 1)));
  endtask

  // response side back-pressure
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_long) begin
        rsp_if.ready <= 1'b0;
        for (stall = 0; stall < LONG_HOLD; stall++) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    int n;
    int blk;
    int share;
    clk_i            = 1'b0;
    rst_ni           = 1'b0;
    req_if.valid     = 1'b0;
    req_if.req_type  = REQ_PUSH_FRONT;
    req_if.push_word = '0;
    req_if.position  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty queue corner cases
    send_request(REQ_POP_FRONT,  32'h1234_5678, 4'd0);
    send_request(REQ_POP_BACK,   32'hFFFF_FFFF, 4'd15);
    send_request(REQ_READ_LAST,  32'h0,         4'd0);
    send_request(REQ_READ_INDEX, 32'h0,         4'd0);
    send_request(REQ_READ_INDEX, 32'hFFFF_FFFF, 4'd15);
    send_request(REQ_UNUSED,     32'hDEAD_BEEF, 4'd7);
    // small mixed sequence
    send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF, 4'd0);
    send_request(REQ_PUSH_BACK,  32'h0000_0000, 4'd15);
    send_request(REQ_PUSH_FRONT, 32'hA5A5_5A5A, 4'd0);
    send_request(REQ_READ_INDEX, 32'h0,         4'd0);
    send_request(REQ_READ_INDEX, 32'h0,         4'd2);
    send_request(REQ_READ_INDEX, 32'h0,         4'd3);
    send_request(REQ_READ_LAST,  32'h0,         4'd0);
    send_request(REQ_UNUSED,     32'h0,         4'd0);
    send_request(REQ_POP_BACK,   32'h0,         4'd0);
    send_request(REQ_POP_FRONT,  32'h0,         4'd0);
    send_request(REQ_CLEAR,      32'hFFFF_FFFF, 4'd15);
    send_request(REQ_READ_LAST,  32'h0,         4'd0);

    // long response stall while pushes keep coming: fills the queue, drops
    // the extra pushes and backs up the request channel
    hold_long = 1'b1;
    for (n = 0; n < 20; n++)
      send_request(n[0] ? REQ_PUSH_FRONT : REQ_PUSH_BACK, $urandom(), '0);
    for (n = 0; n < 20; n++)
      send_request(n[0] ? REQ_POP_FRONT : REQ_POP_BACK, $urandom(), '0);

    // random phases biased to fill, drain or wander; last blocks without gaps
    for (blk = 0; blk < 25; blk++) begin
      case ($urandom_range(0, 2))
        0:       share = 20;
        1:       share = 41;
        default: share = 62;
      endcase
      sender_gaps   = (blk < 21) && ($urandom_range(0, 3) != 0);
      receiver_gaps = (blk < 21) && ($urandom_range(0, 3) != 0);
      for (n = 0; n < 40; n++)
        random_request(share);
    end

    req_if.valid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/bdq_pkg.sv
hdl/bdq_if.sv
hdl/bdq_front.sv
hdl/bdq_cmdq.sv
hdl/bdq_back.sv
hdl/bounded_double_ended_queue.sv
hdl/bdq_checker.sv
tb/bdq_response_checker.sv
tb/bounded_double_ended_queue_test.sv
